FILE: hdl/tmws_pkg.sv
// Shared constants and codes for the tile map window scan block.
`timescale 1ns / 1ps

package tmws_pkg;

    // Default sizes of the tile store.
    localparam int GRID_WIDE_MAX_DEF = 64;
    localparam int GRID_HIGH_MAX_DEF = 64;
    localparam int TILE_ID_BITS_DEF  = 16;

    // Request and result field widths.
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 16;
    localparam int VALUE_W   = 16;
    localparam int ROW_OFF_W = 6;
    localparam int POS_W     = 16;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int GRID_W     = 7;
    localparam int TILE_W     = 9;
    localparam int SCREEN_W   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;

    localparam logic [GRID_W-1:0]   RST_GRID_COLUMNS  = 7'd64;
    localparam logic [GRID_W-1:0]   RST_GRID_ROWS     = 7'd64;
    localparam logic [TILE_W-1:0]   RST_TILE_WIDTH    = 9'd16;
    localparam logic [TILE_W-1:0]   RST_TILE_HEIGHT   = 9'd16;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
    localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT = 12'd240;

    // Divider lanes: magnitude of a 16 bit signed value needs 17 bits.
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = 5;
    localparam int DIV_LANES = 4;
    localparam int REM_W     = 9;

    // Signed width for window bounds (quotient plus span plus one).
    localparam int WIN_W = 18;

endpackage

FILE: hdl/tile_map_window_scan_top.sv
// Top level of the tile map window scan block: tile store, window divider and row scanner.
`timescale 1ns / 1ps

// The block keeps a map of tile ids in one memory with a registered read port
// and answers three kinds of request. A write stores a tile id at a grid cell
// (ignored outside the grid). A read returns the stored id, or a zero id with
// out_of_grid set when the cell lies outside the grid; it reads the memory and
// then waits for the output register. A draw request runs the window setup and
// then walks one map row: four lanes divide the scroll position and the screen
// size by the tile size together, one quotient bit per cycle, the window and
// row states turn the quotients into clamped column and row bounds and start
// positions, and the scanner then reads one map cell per cycle unless a stalled
// output stops the scan, over at most GRID_WIDE_MAX columns of the window. The
// last nonempty tile is known only when the row is done, so each draw entry is
// held back one step before it reaches the output register. After reset the
// block clears all GRID_WIDE_MAX * GRID_HIGH_MAX cells (4096 at the defaults)
// of the memory to empty, and takes no request in that time; configuration
// writes are taken at any time.
module tile_map_window_scan_top #(
    parameter int GRID_WIDE_MAX = tmws_pkg::GRID_WIDE_MAX_DEF,
    parameter int GRID_HIGH_MAX = tmws_pkg::GRID_HIGH_MAX_DEF,
    parameter int TILE_ID_BITS  = tmws_pkg::TILE_ID_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic        [tmws_pkg::KIND_W-1:0]     kind,
    input  logic signed [tmws_pkg::COORD_W-1:0]    cell_x,
    input  logic signed [tmws_pkg::COORD_W-1:0]    cell_y,
    input  logic        [tmws_pkg::VALUE_W-1:0]    tile_value,
    input  logic signed [tmws_pkg::COORD_W-1:0]    scroll_x,
    input  logic signed [tmws_pkg::COORD_W-1:0]    scroll_y,
    input  logic        [tmws_pkg::ROW_OFF_W-1:0]  row_offset,

    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic        [tmws_pkg::VALUE_W-1:0]    tile_id,
    output logic signed [tmws_pkg::POS_W-1:0]      screen_x,
    output logic signed [tmws_pkg::POS_W-1:0]      screen_y,
    output logic                                   out_of_grid,
    output logic                                   is_read_reply,
    output logic                                   last,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [tmws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [tmws_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tmws_pkg::*;

    localparam int DEPTH  = GRID_WIDE_MAX * GRID_HIGH_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TX_W   = (GRID_WIDE_MAX > 1) ? $clog2(GRID_WIDE_MAX) : 1;
    localparam int TXC_W  = $clog2(GRID_WIDE_MAX + 1);
    localparam int TY_W   = (GRID_HIGH_MAX > 1) ? $clog2(GRID_HIGH_MAX) : 1;
    localparam int TYC_W  = $clog2(GRID_HIGH_MAX + 1);
    localparam int ID_W   = TILE_ID_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDATA = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_WIN   = 3'd4;
    localparam logic [2:0] S_ROW   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    // Magnitude of a signed coordinate, exact for the most negative value.
    function automatic logic [DIV_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
        logic signed [DIV_W-1:0] ext;
        ext = DIV_W'(v);
        coord_mag = (v < 0) ? DIV_W'(-ext) : DIV_W'(ext);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [GRID_W-1:0]   grid_columns_reg;
    logic [GRID_W-1:0]   grid_rows_reg;
    logic [TILE_W-1:0]   tile_width_reg;
    logic [TILE_W-1:0]   tile_height_reg;
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg  <= RST_GRID_COLUMNS;
            grid_rows_reg     <= RST_GRID_ROWS;
            tile_width_reg    <= RST_TILE_WIDTH;
            tile_height_reg   <= RST_TILE_HEIGHT;
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_COLUMNS:  grid_columns_reg  <= cfg_data[GRID_W-1:0];
                REG_GRID_ROWS:     grid_rows_reg     <= cfg_data[GRID_W-1:0];
                REG_TILE_WIDTH:    tile_width_reg    <= cfg_data[TILE_W-1:0];
                REG_TILE_HEIGHT:   tile_height_reg   <= cfg_data[TILE_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[SCREEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Effective sizes: a zero tile size acts as one, and the grid is capped
    // at the size of the store.
    logic [TILE_W-1:0]       tw_eff;
    logic [TILE_W-1:0]       th_eff;
    logic signed [WIN_W-1:0] cols_w;
    logic signed [WIN_W-1:0] rows_w;

    assign tw_eff = (tile_width_reg == '0) ? TILE_W'(1) : tile_width_reg;
    assign th_eff = (tile_height_reg == '0) ? TILE_W'(1) : tile_height_reg;
    assign cols_w = (WIN_W'(grid_columns_reg) > WIN_W'(GRID_WIDE_MAX)) ?
                    WIN_W'(GRID_WIDE_MAX) : WIN_W'(grid_columns_reg);
    assign rows_w = (WIN_W'(grid_rows_reg) > WIN_W'(GRID_HIGH_MAX)) ?
                    WIN_W'(GRID_HIGH_MAX) : WIN_W'(grid_rows_reg);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic [2:0]           state_reg,    state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg,  clr_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,  div_cnt_next;
    logic                 rd_vld_reg,   rd_vld_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 out_vld_reg,  out_vld_next;

    logic                    oog_reg,     oog_next;
    logic signed [COORD_W-1:0] scx_reg,   scx_next;
    logic signed [COORD_W-1:0] scy_reg,   scy_next;
    logic [ROW_OFF_W-1:0]    roff_reg,    roff_next;
    logic [DIV_W-1:0]        dvd_reg  [DIV_LANES];
    logic [DIV_W-1:0]        dvd_next [DIV_LANES];
    logic [REM_W-1:0]        rem_reg  [DIV_LANES];
    logic [REM_W-1:0]        rem_next [DIV_LANES];
    logic [TXC_W-1:0]        tx_reg,      tx_next;
    logic [TXC_W-1:0]        txstop_reg,  txstop_next;
    logic [TYC_W-1:0]        ty0_reg,     ty0_next;
    logic [TYC_W-1:0]        tystop_reg,  tystop_next;
    logic [TY_W-1:0]         ty_reg,      ty_next;
    logic [POS_W-1:0]        px_reg,      px_next;
    logic [POS_W-1:0]        py_reg,      py_next;
    logic [POS_W-1:0]        rd_x_reg,    rd_x_next;
    logic [ID_W-1:0]         pend_id_reg, pend_id_next;
    logic [POS_W-1:0]        pend_x_reg,  pend_x_next;
    logic [VALUE_W-1:0]      out_id_reg,  out_id_next;
    logic [POS_W-1:0]        out_x_reg,   out_x_next;
    logic [POS_W-1:0]        out_y_reg,   out_y_next;
    logic                    out_oog_reg, out_oog_next;
    logic                    out_rd_reg,  out_rd_next;
    logic                    out_last_reg, out_last_next;

    // ------------------------------------------------------------------
    // Tile store: one write port and one registered read port.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]   mem [DEPTH];
    logic [ID_W-1:0]   mem_q;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Request decode.
    // ------------------------------------------------------------------
    logic                    item_acc;
    logic signed [WIN_W-1:0] gx_w;
    logic signed [WIN_W-1:0] gy_w;
    logic                    cell_out;
    logic [ADDR_W-1:0]       cell_addr;

    assign item_ready = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign gx_w       = WIN_W'(cell_x);
    assign gy_w       = WIN_W'(cell_y);
    assign cell_out   = (gx_w < 0) || (gy_w < 0) || (gx_w >= cols_w) || (gy_w >= rows_w);
    assign cell_addr  = ADDR_W'(cell_y[TY_W-1:0] * GRID_WIDE_MAX + cell_x[TX_W-1:0]);

    // ------------------------------------------------------------------
    // Divider lanes: restoring division, one quotient bit per cycle. The
    // quotient shifts into the dividend register as the dividend leaves it.
    // ------------------------------------------------------------------
    logic [DIV_W-1:0] div_init [DIV_LANES];
    logic [TILE_W-1:0] div_dsr [DIV_LANES];
    logic [REM_W:0]    div_sh  [DIV_LANES];
    logic              div_ge  [DIV_LANES];

    assign div_init[0] = coord_mag(scroll_x);
    assign div_init[1] = coord_mag(scroll_y);
    assign div_init[2] = DIV_W'(screen_width_reg);
    assign div_init[3] = DIV_W'(screen_height_reg);
    assign div_dsr[0]  = tw_eff;
    assign div_dsr[1]  = th_eff;
    assign div_dsr[2]  = tw_eff;
    assign div_dsr[3]  = th_eff;

    always_comb
    begin
        for (int i = 0; i < DIV_LANES; i++)
        begin
            div_sh[i] = {rem_reg[i], dvd_reg[i][DIV_W-1]};
            div_ge[i] = (div_sh[i] >= (REM_W + 1)'(div_dsr[i]));
        end
    end

    // ------------------------------------------------------------------
    // Window bounds from the quotients (truncated toward zero).
    // ------------------------------------------------------------------
    logic signed [WIN_W-1:0] qx_w, qy_w, tx0_w, ty0_w;
    logic signed [WIN_W-1:0] txstop_w, tystop_w;
    logic signed [WIN_W-1:0] tx0_c, ty0_c, txstop_c, tystop_c;
    logic                    win_exit;
    logic [WIN_W-1:0]        row_sum;
    logic                    row_ok;

    assign qx_w     = $signed({1'b0, dvd_reg[0]});
    assign qy_w     = $signed({1'b0, dvd_reg[1]});
    assign tx0_w    = scx_reg[COORD_W-1] ? -qx_w : qx_w;
    assign ty0_w    = scy_reg[COORD_W-1] ? -qy_w : qy_w;
    assign txstop_w = tx0_w + $signed({1'b0, dvd_reg[2]}) + WIN_W'(1);
    assign tystop_w = ty0_w + $signed({1'b0, dvd_reg[3]}) + WIN_W'(1);
    assign win_exit = (tx0_w >= cols_w) || (ty0_w >= rows_w);
    assign tx0_c    = (tx0_w < 0) ? WIN_W'(0) : tx0_w;
    assign ty0_c    = (ty0_w < 0) ? WIN_W'(0) : ty0_w;
    assign txstop_c = (txstop_w > cols_w) ? cols_w :
                      ((txstop_w < 0) ? WIN_W'(0) : txstop_w);
    assign tystop_c = (tystop_w > rows_w) ? rows_w :
                      ((tystop_w < 0) ? WIN_W'(0) : tystop_w);
    assign row_sum  = WIN_W'(ty0_reg) + WIN_W'(roff_reg);
    assign row_ok   = (row_sum < WIN_W'(tystop_reg));

    // ------------------------------------------------------------------
    // Row scanner. A read is issued per cell; the data comes back in the next
    // cycle with the draw x that belongs to it. A nonempty tile replaces
    // the held entry, which moves on to the output register. The scan
    // stops when that move is blocked, leaving the read data in place.
    // ------------------------------------------------------------------
    logic              out_free;
    logic              rd_nz;
    logic              scan_more;
    logic              scan_stall;
    logic              scan_issue;
    logic [ADDR_W-1:0] scan_addr;

    assign out_free   = !out_vld_reg || result_ready;
    assign rd_nz      = (mem_q != '0);
    assign scan_more  = (tx_reg < txstop_reg);
    assign scan_stall = rd_vld_reg && rd_nz && pend_vld_reg && !out_free;
    assign scan_issue = (state_reg == S_SCAN) && !scan_stall && scan_more;
    assign scan_addr  = ADDR_W'(ty_reg * GRID_WIDE_MAX + tx_reg[TX_W-1:0]);

    // Memory port selection.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = item_acc && (kind == KIND_WRITE) && !cell_out;
            wr_addr = cell_addr;
            wr_data = ID_W'(tile_value);
        end
        rd_en   = scan_issue || (item_acc && (kind == KIND_READ));
        rd_addr = scan_issue ? scan_addr : cell_addr;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        rd_vld_next   = rd_vld_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg && !result_ready;

        oog_next      = oog_reg;
        scx_next      = scx_reg;
        scy_next      = scy_reg;
        roff_next     = roff_reg;
        tx_next       = tx_reg;
        txstop_next   = txstop_reg;
        ty0_next      = ty0_reg;
        tystop_next   = tystop_reg;
        ty_next       = ty_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        rd_x_next     = rd_x_reg;
        pend_id_next  = pend_id_reg;
        pend_x_next   = pend_x_reg;
        out_id_next   = out_id_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_oog_next  = out_oog_reg;
        out_rd_next   = out_rd_reg;
        out_last_next = out_last_reg;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            dvd_next[i] = dvd_reg[i];
            rem_next[i] = rem_reg[i];
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (kind == KIND_READ)
                    begin
                        oog_next   = cell_out;
                        state_next = S_RDATA;
                    end
                    else if (kind == KIND_DRAW)
                    begin
                        scx_next     = scroll_x;
                        scy_next     = scroll_y;
                        roff_next    = row_offset;
                        div_cnt_next = '0;
                        for (int i = 0; i < DIV_LANES; i++)
                        begin
                            dvd_next[i] = div_init[i];
                            rem_next[i] = '0;
                        end
                        state_next = S_DIV;
                    end
                end
            end

            S_RDATA:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_id_next   = oog_reg ? '0 : VALUE_W'(mem_q);
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_oog_next  = oog_reg;
                    out_rd_next   = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_DIV:
            begin
                for (int i = 0; i < DIV_LANES; i++)
                begin
                    dvd_next[i] = {dvd_reg[i][DIV_W-2:0], div_ge[i]};
                    rem_next[i] = div_ge[i] ?
                                  REM_W'(div_sh[i] - (REM_W + 1)'(div_dsr[i])) :
                                  REM_W'(div_sh[i]);
                end
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    state_next = S_WIN;
                end
            end

            S_WIN:
            begin
                tx_next     = TXC_W'(tx0_c);
                txstop_next = TXC_W'(txstop_c);
                ty0_next    = TYC_W'(ty0_c);
                tystop_next = TYC_W'(tystop_c);
                state_next  = win_exit ? S_IDLE : S_ROW;
            end

            S_ROW:
            begin
                ty_next     = TY_W'(row_sum);
                px_next     = POS_W'(tx_reg) * POS_W'(tw_eff) - POS_W'(scx_reg);
                py_next     = POS_W'(row_sum) * POS_W'(th_eff) - POS_W'(scy_reg);
                rd_vld_next = 1'b0;
                state_next  = row_ok ? S_SCAN : S_IDLE;
            end

            S_SCAN:
            begin
                if (!scan_stall)
                begin
                    if (rd_vld_reg && rd_nz)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_vld_next  = 1'b1;
                            out_id_next   = VALUE_W'(pend_id_reg);
                            out_x_next    = pend_x_reg;
                            out_y_next    = py_reg;
                            out_oog_next  = 1'b0;
                            out_rd_next   = 1'b0;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_id_next  = mem_q;
                        pend_x_next   = rd_x_reg;
                    end
                    if (scan_more)
                    begin
                        rd_vld_next = 1'b1;
                        rd_x_next   = px_reg;
                        px_next     = px_reg + POS_W'(tw_eff);
                        tx_next     = tx_reg + TXC_W'(1);
                    end
                    else
                    begin
                        rd_vld_next = 1'b0;
                        if (!rd_vld_reg)
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_id_next   = VALUE_W'(pend_id_reg);
                    out_x_next    = pend_x_reg;
                    out_y_next    = py_reg;
                    out_oog_next  = 1'b0;
                    out_rd_next   = 1'b0;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            rd_vld_reg   <= rd_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        oog_reg      <= oog_next;
        scx_reg      <= scx_next;
        scy_reg      <= scy_next;
        roff_reg     <= roff_next;
        tx_reg       <= tx_next;
        txstop_reg   <= txstop_next;
        ty0_reg      <= ty0_next;
        tystop_reg   <= tystop_next;
        ty_reg       <= ty_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        rd_x_reg     <= rd_x_next;
        pend_id_reg  <= pend_id_next;
        pend_x_reg   <= pend_x_next;
        out_id_reg   <= out_id_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_oog_reg  <= out_oog_next;
        out_rd_reg   <= out_rd_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            dvd_reg[i] <= dvd_next[i];
            rem_reg[i] <= rem_next[i];
        end
    end

    // Result port.
    assign result_valid  = out_vld_reg;
    assign tile_id       = out_id_reg;
    assign screen_x      = out_x_reg;
    assign screen_y      = out_y_reg;
    assign out_of_grid   = out_oog_reg;
    assign is_read_reply = out_rd_reg;
    assign last          = out_last_reg;

`ifndef ASSERT_OFF
    // The scan index never runs past the clamped end of the window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (tx_reg <= txstop_reg))
        else $error("scan index beyond window end");

    // A held draw entry exists only while a row is being scanned or finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> ((state_reg == S_SCAN) || (state_reg == S_FLUSH)))
        else $error("held draw entry outside a row scan");

    // The store is written only by the clearing pass or by an accepted write.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_CLEAR) || (item_acc && (kind == KIND_WRITE))))
        else $error("unexpected tile store write");

    // Read data is in flight only while scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN))
        else $error("scan read data outside a row scan");
`endif

endmodule
